[design/hiop_pkg.sv]
package hiop_pkg;

  // Port store geometry
  localparam int PORT_COUNT = 256;
  localparam int PORT_AW    = 8;

  // Internal EEPROM word address keeps this many bits once doubled
  localparam int INT_EE_BITS = 10;

  // External EEPROM byte address width
  localparam int EXT_AW = 17;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTROLS_FLIPPED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXT_ADDRESS_MASK = 1'd1;
  localparam logic [EXT_AW-1:0]    EXT_MASK_RESET       = 17'd2047;

  // Port numbers with special handling
  localparam logic [7:0] PORT_LEVEL       = 8'hb3;
  localparam logic [7:0] PORT_KEYPAD      = 8'hb5;
  localparam logic [7:0] PORT_SOUND_EXTRA = 8'haa;
  localparam logic [7:0] PORT_INT_DATA_LO = 8'hba;
  localparam logic [7:0] PORT_INT_DATA_HI = 8'hbb;
  localparam logic [7:0] PORT_INT_ADDR_LO = 8'hbc;
  localparam logic [7:0] PORT_INT_ADDR_HI = 8'hbd;
  localparam logic [7:0] PORT_INT_STATUS  = 8'hbe;
  localparam logic [7:0] PORT_BANK        = 8'hc0;
  localparam logic [7:0] PORT_EXT_DATA_LO = 8'hc4;
  localparam logic [7:0] PORT_EXT_DATA_HI = 8'hc5;
  localparam logic [7:0] PORT_EXT_ADDR_LO = 8'hc6;
  localparam logic [7:0] PORT_EXT_ADDR_HI = 8'hc7;
  localparam logic [7:0] PORT_EXT_STATUS  = 8'hc8;
  localparam logic [7:0] PORT_RTC_STATUS  = 8'hca;

  // Read answers
  localparam logic [7:0] SOUND_READ  = 8'hff;
  localparam logic [7:0] LEVEL_MID   = 8'h84;
  localparam logic [7:0] LEVEL_HIGH  = 8'hc4;
  localparam logic [7:0] KEY_SEL_MSK = 8'hf0;
  localparam logic [7:0] BANK_FLAG   = 8'h20;
  localparam logic [7:0] RTC_ACK     = 8'h80;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_KEYS  = 2'd2
  } action_e;

  // One write into the port store
  typedef struct packed {
    logic               en;
    logic [PORT_AW-1:0] addr;
    logic [7:0]         data;
  } port_wr_t;

  // One result transaction
  typedef struct packed {
    logic [7:0]        data;
    logic              to_display;
    logic              ext_request;
    logic              ext_is_write;
    logic [EXT_AW-1:0] ext_address;
  } result_t;

endpackage

[design/hiop_if.sv]
interface hiop_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] port;
  logic [7:0] write_value;
  logic [6:0] key_bits;

  modport source (output valid, action, port, write_value, key_bits, input ready);
  modport sink (input valid, action, port, write_value, key_bits, output ready);
endinterface

interface hiop_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data;
  logic        to_display;
  logic        ext_request;
  logic        ext_is_write;
  logic [16:0] ext_address;

  modport source (output valid, data, to_display, ext_request, ext_is_write, ext_address,
                  input ready);
  modport sink (input valid, data, to_display, ext_request, ext_is_write, ext_address,
                output ready);
endinterface

interface hiop_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [16:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

[design/hiop_port_ram.sv]
module hiop_port_ram (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            rd_en_i,
  input  logic [hiop_pkg::PORT_AW-1:0]    raddr_i,
  input  hiop_pkg::port_wr_t              wr_i,
  output logic [7:0]                      rdata_o
);

  logic [7:0]                      mem [hiop_pkg::PORT_COUNT];
  logic [hiop_pkg::PORT_COUNT-1:0] vld_q;
  logic [7:0]                      rdata_q;

  // Write the array
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // Mark entries written since reset; unwritten entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_i.addr] <= 1'b1;
    end
  end

  // Registered read, forward a write landing on the same edge
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_i.en && (wr_i.addr == raddr_i)) begin
        rdata_q <= wr_i.data;
      end else if (vld_q[raddr_i]) begin
        rdata_q <= mem[raddr_i];
      end else begin
        rdata_q <= '0;
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/hiop_eeprom.sv]
module hiop_eeprom #(
  parameter int BYTES = 1024,
  parameter int AW    = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] raddr_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  output logic [7:0]    rdata_o,
  output logic          busy_o
);

  logic [7:0]    mem [BYTES];
  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;
  logic [7:0]    rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  // Sweep zeros through the array after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      if (clr_addr_q == AW'(BYTES - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
    end
  end

  // Pick the clear sweep or the item write
  always_comb begin
    mem_we    = we_i;
    mem_waddr = waddr_i;
    mem_wdata = wdata_i;
    if (clr_busy_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wdata = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // Registered read with write forwarding
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = clr_busy_q;

endmodule

[design/handheld_io_port_block.sv]
// I/O port block of a handheld console: every input transaction is a port read, a port
// write or a key-state load, and yields exactly one result transaction. The block takes
// one transaction per clock while the result is not stalled, and returns its result
// through the input stage, which sees the registered port-store and EEPROM reads, and
// then the result register; that rate is set by the single read port of each store,
// with writes of the preceding transaction forwarded into the read. A stalled result
// stalls input. After reset the internal EEPROM is swept to zero, one byte per cycle,
// during which no input transaction is taken; configuration writes are always taken
// and must only happen while the block is idle.
module handheld_io_port_block #(
  parameter int EEPROM_BYTES = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  hiop_in_if.sink           in_i,
  hiop_out_if.source        out_o,
  hiop_cfg_if.sink          cfg_i
);

  localparam int EeAw     = $clog2(EEPROM_BYTES);
  localparam int IntW     = hiop_pkg::INT_EE_BITS;
  localparam int ModSteps = ((1 << IntW) - 1) / EEPROM_BYTES;

  // Doubled word address plus byte select, kept to IntW bits, reduced into the array
  function automatic logic [EeAw-1:0] ee_index(logic [15:0] w, logic odd);
    logic [IntW-1:0] r;
    r = {w[IntW-2:0], odd};
    for (int i = 0; i < ModSteps; i++) begin
      if (int'(r) >= EEPROM_BYTES) begin
        r = r - IntW'(EEPROM_BYTES);
      end
    end
    return EeAw'(r);
  endfunction

  // Configuration
  logic                        flipped_q;
  logic [hiop_pkg::EXT_AW-1:0] ext_mask_q;

  // Input stage
  logic                 s1_valid_q;
  hiop_pkg::action_e    s1_action_q;
  logic [7:0]           s1_port_q;
  logic [7:0]           s1_val_q;
  logic [6:0]           s1_keys_q;

  // Architectural state kept in flops
  logic [6:0] key_q;
  logic [7:0] ee_lo_q, ee_hi_q, ext_lo_q, ext_hi_q;
  logic [7:0] ee_lo_d, ee_hi_d, ext_lo_d, ext_hi_d;

  // Result register
  logic              out_valid_q;
  hiop_pkg::result_t res_q;
  hiop_pkg::result_t res_d;

  logic               advance;
  logic               accept;
  logic               ee_busy;
  logic [7:0]         store_rd;
  logic [7:0]         ee_rd;
  hiop_pkg::port_wr_t pst_wr;
  logic               ee_we;
  logic [EeAw-1:0]    ee_waddr;
  logic [EeAw-1:0]    ee_raddr;
  logic               key_we;

  assign advance     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !ee_busy && (!s1_valid_q || advance);
  assign accept      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // Take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flipped_q  <= 1'b0;
      ext_mask_q <= hiop_pkg::EXT_MASK_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        hiop_pkg::CFG_CONTROLS_FLIPPED: flipped_q  <= cfg_i.wdata[0];
        hiop_pkg::CFG_EXT_ADDRESS_MASK: ext_mask_q <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  // Load the input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_action_q <= hiop_pkg::action_e'(in_i.action);
      s1_port_q   <= in_i.port;
      s1_val_q    <= in_i.write_value;
      s1_keys_q   <= in_i.key_bits;
    end
  end

  // Work out the result and the state updates of the item in the input stage
  always_comb begin
    logic [3:0] grp;
    logic [15:0] ext_w;
    logic [hiop_pkg::EXT_AW-1:0] ext_addr;
    logic st, lf, rt, up, dn, b1, b2;
    st = key_q[0];
    lf = key_q[1];
    rt = key_q[2];
    up = key_q[3];
    dn = key_q[4];
    b1 = key_q[5];
    b2 = key_q[6];
    grp = '0;
    ext_w = {ext_hi_q, ext_lo_q};
    ext_addr = ({ext_w, 1'b0} & ext_mask_q)
               | {{(hiop_pkg::EXT_AW-1){1'b0}}, s1_port_q == hiop_pkg::PORT_EXT_DATA_HI};

    res_d       = '0;
    pst_wr.en   = 1'b0;
    pst_wr.addr = s1_port_q;
    pst_wr.data = s1_val_q;
    ee_we       = 1'b0;
    key_we      = 1'b0;

    case (s1_action_q)
      hiop_pkg::ACT_KEYS: key_we = advance;
      hiop_pkg::ACT_READ: begin
        if (s1_port_q inside {[8'h4e:8'h51], [8'h80:8'h94], hiop_pkg::PORT_SOUND_EXTRA}) begin
          res_d.data = hiop_pkg::SOUND_READ;
        end else if (s1_port_q == hiop_pkg::PORT_LEVEL) begin
          if (!store_rd[7]) begin
            res_d.data = '0;
          end else if (!store_rd[6]) begin
            res_d.data = hiop_pkg::LEVEL_MID;
          end else begin
            res_d.data = hiop_pkg::LEVEL_HIGH;
          end
        end else if (s1_port_q == hiop_pkg::PORT_KEYPAD) begin
          // Select one key group; the layout flag swaps the keys in each group
          if (store_rd[6]) begin
            grp = flipped_q ? {2'b00, st, 1'b0} : {b2, b1, st, 1'b0};
            res_d.data = (store_rd & hiop_pkg::KEY_SEL_MSK) | {4'h0, grp};
          end else if (store_rd[5]) begin
            grp = flipped_q ? {1'b0, b2, 1'b0, b1} : {lf, dn, rt, up};
            res_d.data = (store_rd & hiop_pkg::KEY_SEL_MSK) | {4'h0, grp};
          end else if (store_rd[4]) begin
            grp = flipped_q ? {dn, rt, up, lf} : 4'h0;
            res_d.data = (store_rd & hiop_pkg::KEY_SEL_MSK) | {4'h0, grp};
          end else begin
            res_d.to_display = 1'b1;
          end
        end else if (s1_port_q == hiop_pkg::PORT_INT_STATUS ||
                     s1_port_q == hiop_pkg::PORT_EXT_STATUS) begin
          // Acknowledge the pending EEPROM command
          if (store_rd[5]) begin
            res_d.data = store_rd | 8'h02;
          end else if (store_rd[4]) begin
            res_d.data = store_rd | 8'h01;
          end else begin
            res_d.data = store_rd | 8'h03;
          end
        end else if (s1_port_q == hiop_pkg::PORT_INT_DATA_LO ||
                     s1_port_q == hiop_pkg::PORT_INT_DATA_HI) begin
          res_d.data = ee_rd;
        end else if (s1_port_q == hiop_pkg::PORT_BANK) begin
          res_d.data = {4'h0, store_rd[3:0]} | hiop_pkg::BANK_FLAG;
        end else if (s1_port_q == hiop_pkg::PORT_EXT_DATA_LO ||
                     s1_port_q == hiop_pkg::PORT_EXT_DATA_HI) begin
          res_d.ext_request = 1'b1;
          res_d.ext_address = ext_addr;
        end else if (s1_port_q == hiop_pkg::PORT_RTC_STATUS) begin
          res_d.data = store_rd | hiop_pkg::RTC_ACK;
        end else begin
          res_d.to_display = 1'b1;
        end
      end
      hiop_pkg::ACT_WRITE: begin
        // Drop a write that repeats the stored byte
        if (store_rd != s1_val_q) begin
          pst_wr.en = advance;
          if (s1_port_q == hiop_pkg::PORT_INT_DATA_LO ||
              s1_port_q == hiop_pkg::PORT_INT_DATA_HI) begin
            ee_we = advance;
          end else if (s1_port_q == hiop_pkg::PORT_EXT_DATA_LO ||
                       s1_port_q == hiop_pkg::PORT_EXT_DATA_HI) begin
            res_d.ext_request  = 1'b1;
            res_d.ext_is_write = 1'b1;
            res_d.data         = s1_val_q;
            res_d.ext_address  = ext_addr;
          end else begin
            res_d.to_display = 1'b1;
            res_d.data       = s1_val_q;
          end
        end
      end
      default: ;
    endcase
  end

  assign ee_waddr = ee_index({ee_hi_q, ee_lo_q}, s1_port_q == hiop_pkg::PORT_INT_DATA_HI);

  // Address registers as they stand after this edge's write
  always_comb begin
    ee_lo_d  = ee_lo_q;
    ee_hi_d  = ee_hi_q;
    ext_lo_d = ext_lo_q;
    ext_hi_d = ext_hi_q;
    if (pst_wr.en) begin
      case (pst_wr.addr)
        hiop_pkg::PORT_INT_ADDR_LO: ee_lo_d  = pst_wr.data;
        hiop_pkg::PORT_INT_ADDR_HI: ee_hi_d  = pst_wr.data;
        hiop_pkg::PORT_EXT_ADDR_LO: ext_lo_d = pst_wr.data;
        hiop_pkg::PORT_EXT_ADDR_HI: ext_hi_d = pst_wr.data;
        default: ;
      endcase
    end
  end

  assign ee_raddr = ee_index({ee_hi_d, ee_lo_d}, in_i.port == hiop_pkg::PORT_INT_DATA_HI);

  // Hold copies of the address ports and the key state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ee_lo_q  <= '0;
      ee_hi_q  <= '0;
      ext_lo_q <= '0;
      ext_hi_q <= '0;
      key_q    <= '0;
    end else begin
      ee_lo_q  <= ee_lo_d;
      ee_hi_q  <= ee_hi_d;
      ext_lo_q <= ext_lo_d;
      ext_hi_q <= ext_hi_d;
      if (key_we) begin
        key_q <= s1_keys_q;
      end
    end
  end

  hiop_port_ram u_port_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (accept),
    .raddr_i (in_i.port),
    .wr_i    (pst_wr),
    .rdata_o (store_rd)
  );

  hiop_eeprom #(
    .BYTES (EEPROM_BYTES),
    .AW    (EeAw)
  ) u_eeprom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (accept),
    .raddr_i (ee_raddr),
    .we_i    (ee_we),
    .waddr_i (ee_waddr),
    .wdata_i (s1_val_q),
    .rdata_o (ee_rd),
    .busy_o  (ee_busy)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.data         = res_q.data;
  assign out_o.to_display   = res_q.to_display;
  assign out_o.ext_request  = res_q.ext_request;
  assign out_o.ext_is_write = res_q.ext_is_write;
  assign out_o.ext_address  = res_q.ext_address;

  // No transaction enters during the EEPROM clear sweep
  a_no_accept_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ee_busy |-> !accept)
    else $error("input accepted during EEPROM clear");

  // An accepted transaction sits in the input stage on the next cycle
  a_accept_loads_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted transaction lost");

  // Display and external EEPROM are never both addressed
  a_one_target : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.to_display && res_q.ext_request))
    else $error("result routed to two units");

  // An external write implies a request; no request means no address
  a_ext_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.ext_request) |-> (!res_q.ext_is_write && res_q.ext_address == '0))
    else $error("external fields set without request");

  // Port store and EEPROM item writes happen only when the stage advances
  a_write_on_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pst_wr.en || ee_we) |-> advance)
    else $error("store written while stalled");

endmodule
